// ----- design/bce_pkg.sv -----
// Shared constants, codes and control types for the Bezier curve evaluator.
`timescale 1ns / 1ps

package bce_pkg;

    // Default sizing of the block
    localparam int MAX_POINTS_DEF      = 8;
    localparam int COORD_WIDTH_DEF     = 32;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    // Fixed field widths of the item and the register
    localparam int POINT_COUNT_W = 4;
    localparam int INDEX_W       = 3;
    localparam int ORDER_W       = 2;

    // Headroom of the working values over the coordinate width:
    // two scaled difference passes grow a value by at most this many bits
    localparam int GROWTH_BITS = 10;

    localparam logic [POINT_COUNT_W-1:0] POINT_COUNT_RST = 4'd4;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Derivative order codes
    localparam logic [ORDER_W-1:0] ORDER_POS = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_D1  = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_D2  = 2'd2;

    // Control of the pass pipeline for one read beat
    typedef struct packed {
        logic issue;     // a read of the pass source was issued this cycle
        logic first;     // the read is of entry 0 of the pass
        logic lerp;      // pass interpolates; otherwise it forms scaled differences
        logic src_work;  // pass reads the work memory; otherwise the point store
    } bce_pipe_ctl_t;

endpackage

// ----- design/bce_ram.sv -----
// Generic single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps

module bce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bce_pass_pipe.sv -----
// Pass pipeline: pairs neighbor entries, multiplies and writes one result per pair.
`timescale 1ns / 1ps

module bce_pass_pipe #(
    parameter int MAX_POINTS      = bce_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH     = bce_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = bce_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  bce_pkg::bce_pipe_ctl_t                        ctl,
    input  logic [$clog2(MAX_POINTS)-1:0]                 rd_idx,
    input  logic [PARAM_FRAC_BITS:0]                      mult,
    input  logic [2*COORD_WIDTH-1:0]                      store_rdata,
    input  logic [2*(COORD_WIDTH+bce_pkg::GROWTH_BITS)-1:0] work_rdata,
    output logic                                          wr_en,
    output logic [$clog2(MAX_POINTS)-1:0]                 wr_addr,
    output logic [2*(COORD_WIDTH+bce_pkg::GROWTH_BITS)-1:0] wr_data,
    output logic                                          busy
);

    import bce_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int WW = COORD_WIDTH + GROWTH_BITS;
    localparam int UW = PARAM_FRAC_BITS + 1;
    localparam int DW = WW + 1;
    localparam int PW = DW + UW + 1;
    localparam logic signed [PW-1:0] HALF =
        {{(PW-1){1'b0}}, 1'b1} << (PARAM_FRAC_BITS - 1);

    // Read beat in flight, aligned with the memory data
    logic          v0_reg;
    logic          first0_reg;
    logic [AW-1:0] idx0_reg;

    // Difference stage
    logic [WW-1:0] prev_x_reg, prev_y_reg;
    logic          v1_reg;
    logic [AW-1:0] idx1_reg;
    logic [WW-1:0] a1_x_reg, a1_y_reg;
    logic [DW-1:0] d_x_reg, d_y_reg;

    // Product stage
    logic          v2_reg;
    logic [AW-1:0] idx2_reg;
    logic [WW-1:0] a2_x_reg, a2_y_reg;
    logic [PW-1:0] p_x_reg, p_y_reg;

    logic [WW-1:0]        cur_x, cur_y;
    logic signed [PW-1:0] prod_x, prod_y;
    logic signed [PW-1:0] rnd_x, rnd_y;
    logic signed [PW-1:0] sh_x, sh_y;
    logic [WW-1:0]        res_x, res_y;

    // Select the incoming entry, widened to the working width
    always_comb begin
        if (ctl.src_work) begin
            cur_x = work_rdata[WW-1:0];
            cur_y = work_rdata[2*WW-1:WW];
        end else begin
            cur_x = {{GROWTH_BITS{store_rdata[COORD_WIDTH-1]}},
                     store_rdata[COORD_WIDTH-1:0]};
            cur_y = {{GROWTH_BITS{store_rdata[2*COORD_WIDTH-1]}},
                     store_rdata[2*COORD_WIDTH-1:COORD_WIDTH]};
        end
    end

    // One multiplier per axis: difference times parameter or degree
    assign prod_x = $signed(d_x_reg) * $signed({1'b0, mult});
    assign prod_y = $signed(d_y_reg) * $signed({1'b0, mult});

    // Round half up and add the lower point, or keep the scaled difference
    assign rnd_x = $signed(p_x_reg) + HALF;
    assign rnd_y = $signed(p_y_reg) + HALF;
    assign sh_x  = rnd_x >>> PARAM_FRAC_BITS;
    assign sh_y  = rnd_y >>> PARAM_FRAC_BITS;
    assign res_x = ctl.lerp ? a2_x_reg + sh_x[WW-1:0] : p_x_reg[WW-1:0];
    assign res_y = ctl.lerp ? a2_y_reg + sh_y[WW-1:0] : p_y_reg[WW-1:0];

    // Advance beats through the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= ctl.issue;
            v1_reg <= v0_reg && !first0_reg;
            v2_reg <= v1_reg;
        end
        first0_reg <= ctl.first;
        idx0_reg   <= rd_idx - AW'(1);
        if (v0_reg) begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        idx1_reg <= idx0_reg;
        a1_x_reg <= prev_x_reg;
        a1_y_reg <= prev_y_reg;
        d_x_reg  <= {cur_x[WW-1], cur_x} - {prev_x_reg[WW-1], prev_x_reg};
        d_y_reg  <= {cur_y[WW-1], cur_y} - {prev_y_reg[WW-1], prev_y_reg};
        idx2_reg <= idx1_reg;
        a2_x_reg <= a1_x_reg;
        a2_y_reg <= a1_y_reg;
        p_x_reg  <= prod_x;
        p_y_reg  <= prod_y;
    end

    assign wr_en   = v2_reg;
    assign wr_addr = idx2_reg;
    assign wr_data = {res_y, res_x};
    assign busy    = v0_reg || v1_reg || v2_reg;

endmodule

// ----- design/bezier_curve_evaluator_top.sv -----
// Top level: point store, work memory, pass sequencer and result register.
// Load beat: writes the point store, gives no result.
// Evaluate beat: each pass over L entries streams its reads through the read port of
// the pass source (point store or work memory), then the three-stage multiply pipeline
// drains; after the last pass the result is fetched, clipped and emitted.
// Too few points or an unused order: a zero result, with no passes run.
// Reset (synchronous, active low) clears control and sets point_count to 4.
`timescale 1ns / 1ps

module bezier_curve_evaluator_top #(
    parameter int MAX_POINTS      = bce_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH     = bce_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = bce_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bce_pkg::POINT_COUNT_W-1:0]    cfg_data,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic [bce_pkg::INDEX_W-1:0]          s_point_index,
    input  logic signed [COORD_WIDTH-1:0]        s_x_in,
    input  logic signed [COORD_WIDTH-1:0]        s_y_in,
    input  logic signed [PARAM_FRAC_BITS+1:0]    s_param,
    input  logic [bce_pkg::ORDER_W-1:0]          s_deriv_order,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [COORD_WIDTH-1:0]        m_x_out,
    output logic signed [COORD_WIDTH-1:0]        m_y_out,
    output logic                                 m_saturated
);

    import bce_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int WW = COORD_WIDTH + GROWTH_BITS;
    localparam int UW = PARAM_FRAC_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_RUN,
        ST_FETCH,
        ST_CLIP,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [POINT_COUNT_W-1:0]  point_count_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic [CW-1:0]             len_reg;
    logic [CW-1:0]             cnt_reg;
    logic [ORDER_W-1:0]        diff_left_reg;
    logic                      lerp_reg;
    logic                      pass_src_reg;
    logic                      next_src_reg;
    logic [UW-1:0]             u_reg;
    logic [COORD_WIDTH-1:0]    res_x_reg, res_y_reg;
    logic                      res_sat_reg;
    logic                      m_valid_reg;
    logic [COORD_WIDTH-1:0]    m_x_reg, m_y_reg;
    logic                      m_sat_reg;

    logic                      accept;
    logic                      store_we;
    logic [AW-1:0]             store_waddr;
    logic [AW-1:0]             rd_addr;
    logic [2*COORD_WIDTH-1:0]  store_rdata;
    logic [2*WW-1:0]           work_rdata;
    logic                      work_we;
    logic [AW-1:0]             work_waddr;
    logic [2*WW-1:0]           work_wdata;
    logic                      pipe_busy;
    bce_pipe_ctl_t             pipe_ctl;
    logic [UW-1:0]             mult;
    logic [CW-1:0]             n_eff;
    logic                      too_few;
    logic [UW-1:0]             u_clamped;
    logic                      last_read;
    logic [WW-1:0]             fin_x, fin_y;
    logic [COORD_WIDTH:0]      clip_x, clip_y;

    // Clip a working value to the coordinate range; top bit is the flag
    function automatic logic [COORD_WIDTH:0] clip_val(input logic [WW-1:0] v);
        logic                   ovf;
        logic [COORD_WIDTH-1:0] r;
        ovf = !((&v[WW-1:COORD_WIDTH-1]) || !(|v[WW-1:COORD_WIDTH-1]));
        r   = v[COORD_WIDTH-1:0];
        if (ovf) begin
            r = v[WW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                        : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return {ovf, r};
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    // Load beats write the point store; slots beyond the store are dropped
    assign store_we    = accept && (s_operation == OP_LOAD)
                         && (int'(s_point_index) < MAX_POINTS);
    assign store_waddr = AW'(s_point_index);

    // Reads follow the pass counter, or entry 0 for the final fetch
    assign rd_addr = (state_reg == ST_RUN) ? rd_idx_reg : '0;

    // Clamp the parameter to 0..1.0
    always_comb begin
        if (s_param[PARAM_FRAC_BITS+1]) begin
            u_clamped = '0;
        end else if (s_param[PARAM_FRAC_BITS] && (|s_param[PARAM_FRAC_BITS-1:0])) begin
            u_clamped = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
        end else begin
            u_clamped = s_param[PARAM_FRAC_BITS:0];
        end
    end

    // Points in use and the check for enough points
    assign n_eff   = (int'(point_count_reg) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                          : CW'(point_count_reg);
    assign too_few = (s_deriv_order > ORDER_D2) || (n_eff <= CW'(s_deriv_order));

    assign last_read = (CW'(rd_idx_reg) == len_reg - CW'(1));

    assign pipe_ctl.issue    = (state_reg == ST_RUN);
    assign pipe_ctl.first    = (rd_idx_reg == '0);
    assign pipe_ctl.lerp     = lerp_reg;
    assign pipe_ctl.src_work = pass_src_reg;
    assign mult = lerp_reg ? u_reg : UW'(len_reg - CW'(1));

    // Final value from whichever memory the last pass left it in
    always_comb begin
        if (pass_src_reg) begin
            fin_x = work_rdata[WW-1:0];
            fin_y = work_rdata[2*WW-1:WW];
        end else begin
            fin_x = {{GROWTH_BITS{store_rdata[COORD_WIDTH-1]}},
                     store_rdata[COORD_WIDTH-1:0]};
            fin_y = {{GROWTH_BITS{store_rdata[2*COORD_WIDTH-1]}},
                     store_rdata[2*COORD_WIDTH-1:COORD_WIDTH]};
        end
    end
    assign clip_x = clip_val(fin_x);
    assign clip_y = clip_val(fin_y);

    bce_ram #(
        .WIDTH (2*COORD_WIDTH),
        .DEPTH (MAX_POINTS)
    ) u_point_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata ({s_y_in, s_x_in}),
        .raddr (rd_addr),
        .rdata (store_rdata)
    );

    bce_ram #(
        .WIDTH (2*WW),
        .DEPTH (MAX_POINTS)
    ) u_work_mem (
        .aclk  (aclk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (rd_addr),
        .rdata (work_rdata)
    );

    bce_pass_pipe #(
        .MAX_POINTS      (MAX_POINTS),
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_pass_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (pipe_ctl),
        .rd_idx      (rd_idx_reg),
        .mult        (mult),
        .store_rdata (store_rdata),
        .work_rdata  (work_rdata),
        .wr_en       (work_we),
        .wr_addr     (work_waddr),
        .wr_data     (work_wdata),
        .busy        (pipe_busy)
    );

    // Sequencer, configuration register and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            point_count_reg <= POINT_COUNT_RST;
            m_valid_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            len_reg         <= '0;
            cnt_reg         <= '0;
            diff_left_reg   <= '0;
            lerp_reg        <= 1'b0;
            pass_src_reg    <= 1'b0;
            next_src_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                point_count_reg <= cfg_data;
            end
            // drop the result once taken
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_operation == OP_EVAL)) begin
                        u_reg <= u_clamped;
                        if (too_few) begin
                            res_x_reg   <= '0;
                            res_y_reg   <= '0;
                            res_sat_reg <= 1'b0;
                            state_reg   <= ST_EMIT;
                        end else begin
                            cnt_reg       <= n_eff;
                            diff_left_reg <= s_deriv_order;
                            next_src_reg  <= 1'b0;
                            state_reg     <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    // start the next pass once earlier writes have landed
                    if (!pipe_busy) begin
                        pass_src_reg <= next_src_reg;
                        if (diff_left_reg != '0) begin
                            lerp_reg      <= 1'b0;
                            len_reg       <= cnt_reg;
                            cnt_reg       <= cnt_reg - CW'(1);
                            diff_left_reg <= diff_left_reg - ORDER_W'(1);
                            next_src_reg  <= 1'b1;
                            rd_idx_reg    <= '0;
                            state_reg     <= ST_RUN;
                        end else if (cnt_reg > CW'(1)) begin
                            lerp_reg     <= 1'b1;
                            len_reg      <= cnt_reg;
                            cnt_reg      <= cnt_reg - CW'(1);
                            next_src_reg <= 1'b1;
                            rd_idx_reg   <= '0;
                            state_reg    <= ST_RUN;
                        end else begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_RUN: begin
                    if (last_read) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        rd_idx_reg <= rd_idx_reg + AW'(1);
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_CLIP;
                end
                ST_CLIP: begin
                    res_x_reg   <= clip_x[COORD_WIDTH-1:0];
                    res_y_reg   <= clip_y[COORD_WIDTH-1:0];
                    res_sat_reg <= clip_x[COORD_WIDTH] || clip_y[COORD_WIDTH];
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT: begin
                    // hold until the result register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_x_reg     <= res_x_reg;
                        m_y_reg     <= res_y_reg;
                        m_sat_reg   <= res_sat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_x_out     = m_x_reg;
    assign m_y_out     = m_y_reg;
    assign m_saturated = m_sat_reg;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Bezier curve evaluator: directed table plus random phases.
`timescale 1ns / 1ps

module testbench;
    import bce_pkg::*;

    localparam int CW   = COORD_WIDTH_DEF;
    localparam int PF   = PARAM_FRAC_BITS_DEF;
    localparam int MAXP = MAX_POINTS_DEF;

    localparam longint UNIT_PARAM = longint'(1) <<< PF;
    localparam longint HALF_LSB   = longint'(1) <<< (PF - 1);
    localparam longint COORD_HI   = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_LO   = -COORD_HI - 1;

    localparam logic [ORDER_W-1:0] ORDER_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 500;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 120;
    localparam int REPORT_LINES  = 40;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 sat;
    } curve_result_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [3:0]           sel;      // slot for a load, point count for a register write
        logic [CW-1:0]        x;
        logic [CW-1:0]        y;
        logic [PF+1:0]        prm;
        logic [ORDER_W-1:0]   ord;
        logic                 typed;    // result is written out in the row
        curve_result_t        want;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [POINT_COUNT_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic s_operation;
    logic [INDEX_W-1:0] s_point_index;
    logic signed [CW-1:0] s_x_in;
    logic signed [CW-1:0] s_y_in;
    logic signed [PF+1:0] s_param;
    logic [ORDER_W-1:0] s_deriv_order;
    logic m_valid;
    logic m_ready;
    logic signed [CW-1:0] m_x_out;
    logic signed [CW-1:0] m_y_out;
    logic m_saturated;

    // typed result travelling with the current input beat
    logic          beat_typed;
    curve_result_t beat_want;

    // predictor state
    longint                   point_x_mirror [MAXP];
    longint                   point_y_mirror [MAXP];
    logic [POINT_COUNT_W-1:0] count_mirror;

    curve_result_t curve_due_q [$];
    int  err_count   = 0;
    int  cycle_count = 0;
    bit  tx_gaps     = 1'b1;
    bit  rx_gaps     = 1'b1;
    int  hold_request = 0;

    logic [CW-1:0]   coord_edges [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    logic [PF+1:0]   param_edges [8] = '{18'd0, 18'd1, 18'd65535, 18'd65536, 18'd65537,
                                         18'h3FFFF, 18'h20000, 18'h1FFFF};

    bezier_curve_evaluator_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_point_index (s_point_index),
        .s_x_in        (s_x_in),
        .s_y_in        (s_y_in),
        .s_param       (s_param),
        .s_deriv_order (s_deriv_order),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_x_out       (m_x_out),
        .m_y_out       (m_y_out),
        .m_saturated   (m_saturated)
    );

    always #6 aclk = ~aclk;

    // One rounded interpolation step from a toward b
    function automatic longint lerp_step(input longint a, input longint b, input longint u);
        return a + (((b - a) * u + HALF_LSB) >>> PF);
    endfunction

    // Curve point or derivative from the mirrored control points
    function automatic curve_result_t eval_curve(input logic signed [PF+1:0] prm,
                                                 input logic [ORDER_W-1:0] ord);
        longint wx [MAXP];
        longint wy [MAXP];
        longint u;
        longint deg;
        int n;
        int i;
        int k;
        int r;
        curve_result_t res;
        res = '0;
        u = longint'(prm);
        if (u < 0) u = 0;
        if (u > UNIT_PARAM) u = UNIT_PARAM;
        n = (int'(count_mirror) > MAXP) ? MAXP : int'(count_mirror);
        if (ord > ORDER_D2 || n < int'(ord) + 1) return res;
        for (i = 0; i < n; i++) begin
            wx[i] = point_x_mirror[i];
            wy[i] = point_y_mirror[i];
        end
        // scaled difference passes, one per derivative order
        for (k = 0; k < int'(ord); k++) begin
            deg = n - 1;
            for (i = 0; i + 1 < n; i++) begin
                wx[i] = deg * (wx[i + 1] - wx[i]);
                wy[i] = deg * (wy[i + 1] - wy[i]);
            end
            n--;
        end
        for (r = 1; r < n; r++) begin
            for (i = 0; i + r < n; i++) begin
                wx[i] = lerp_step(wx[i], wx[i + 1], u);
                wy[i] = lerp_step(wy[i], wy[i + 1], u);
            end
        end
        res.sat = (wx[0] > COORD_HI) || (wx[0] < COORD_LO) ||
                  (wy[0] > COORD_HI) || (wy[0] < COORD_LO);
        res.x = (wx[0] > COORD_HI) ? COORD_HI : (wx[0] < COORD_LO) ? COORD_LO : wx[0];
        res.y = (wy[0] > COORD_HI) ? COORD_HI : (wy[0] < COORD_LO) ? COORD_LO : wy[0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < REPORT_LINES)
            $display("mismatch at cycle %0d, %s: got %0d, want %0d", cycle_count, what, got, want);
        err_count++;
    endtask

    // Random coordinate: full range, small values, extremes or mid-range
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            2: return coord_edges[$urandom_range(0, 3)];
            default: return CW'($signed($urandom) >>> 8);
        endcase
    endfunction

    // Offer one input beat, optionally after a random gap, and hold it until taken
    task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [PF+1:0] prm, input logic [ORDER_W-1:0] ord,
                             input logic typed, input curve_result_t want);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_point_index <= idx;
        s_x_in        <= x;
        s_y_in        <= y;
        s_param       <= prm;
        s_deriv_order <= ord;
        beat_typed    <= typed;
        beat_want     <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every result is back and the block has settled
    task automatic drain_results();
        s_valid <= 1'b0;
        while (curve_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_point_count(input logic [POINT_COUNT_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t row_of(input row_kind_t kind, input logic [3:0] sel,
                                         input logic [CW-1:0] x, input logic [CW-1:0] y,
                                         input logic [PF+1:0] prm,
                                         input logic [ORDER_W-1:0] ord, input logic typed,
                                         input logic [CW-1:0] wx, input logic [CW-1:0] wy,
                                         input logic wsat);
        stim_row_t row;
        row.kind     = kind;
        row.sel      = sel;
        row.x        = x;
        row.y        = y;
        row.prm      = prm;
        row.ord      = ord;
        row.typed    = typed;
        row.want.x   = wx;
        row.want.y   = wy;
        row.want.sat = wsat;
        return row;
    endfunction

    // Track config and input beats, check result beats
    always @(posedge aclk) begin : scoreboard
        curve_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (curve_due_q.size() == 0) begin
                    report_mismatch("result with nothing pending, x_out", m_x_out, 0);
                end else begin
                    want = curve_due_q.pop_front();
                    if (m_x_out !== want.x) report_mismatch("x_out", m_x_out, want.x);
                    if (m_y_out !== want.y) report_mismatch("y_out", m_y_out, want.y);
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", m_saturated, want.sat);
                end
            end
            if (cfg_valid && cfg_ready) count_mirror = cfg_data;
            if (s_valid && s_ready) begin
                if (s_operation == OP_LOAD) begin
                    point_x_mirror[s_point_index] = longint'(s_x_in);
                    point_y_mirror[s_point_index] = longint'(s_y_in);
                end else begin
                    curve_due_q.push_back(beat_typed ? beat_want
                                                     : eval_curve(s_param, s_deriv_order));
                end
            end
        end else begin
            count_mirror = POINT_COUNT_RST;
        end
    end

    // Result side: random stall bursts and one long hold-off on request
    always @(posedge aclk) begin : result_sink
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (hold_request > 0) begin
            stall_left = hold_request - 1;
            hold_request = 0;
            m_ready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t plan [$];
        stim_row_t row;
        logic [3:0] phase_pc [7];
        logic [PF+1:0] rp;
        logic [ORDER_W-1:0] ro;
        logic op;
        int p;
        int i;
        int pick;

        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_operation   = OP_LOAD;
        s_point_index = '0;
        s_x_in        = '0;
        s_y_in        = '0;
        s_param       = '0;
        s_deriv_order = ORDER_POS;
        m_ready       = 1'b0;
        beat_typed    = 1'b0;
        beat_want     = '0;
        phase_pc      = '{4'd8, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3, 4'd7};

        // straight line through the first four slots, extremes in the rest
        plan.push_back(row_of(ROW_LOAD, 0, 32'h0, 32'h0, 0, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_LOAD, 1, 32'h1_0000, 32'h2_0000, 0, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_LOAD, 2, 32'h2_0000, 32'h4_0000, 0, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_LOAD, 3, 32'h3_0000, 32'h6_0000, 0, ORDER_POS, 0, 0, 0, 0));
        // reset point count of four: ends, clamped parameters, derivatives, unused order
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'd0, ORDER_POS, 1, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'd65536, ORDER_POS, 1,
                              32'h3_0000, 32'h6_0000, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h20000, ORDER_POS, 1, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h1FFFF, ORDER_POS, 1,
                              32'h3_0000, 32'h6_0000, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h8000, ORDER_D1, 1,
                              32'h3_0000, 32'h6_0000, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h4000, ORDER_D2, 1, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h8000, ORDER_UNUSED, 1, 0, 0, 0));
        plan.push_back(row_of(ROW_LOAD, 4, 32'h7FFF_FFFF, 32'h8000_0000, 0, ORDER_POS, 0,
                              0, 0, 0));
        plan.push_back(row_of(ROW_LOAD, 5, 32'h8000_0000, 32'h7FFF_FFFF, 0, ORDER_POS, 0,
                              0, 0, 0));
        plan.push_back(row_of(ROW_LOAD, 6, 32'h7FFF_FFFF, 32'h8000_0000, 0, ORDER_POS, 0,
                              0, 0, 0));
        plan.push_back(row_of(ROW_LOAD, 7, 32'h8000_0000, 32'h7FFF_FFFF, 0, ORDER_POS, 0,
                              0, 0, 0));
        // point count above the store is taken as the store size
        plan.push_back(row_of(ROW_CFG, 15, 0, 0, 0, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h8000, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'd65536, ORDER_POS, 1,
                              32'h8000_0000, 32'h7FFF_FFFF, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'hC000, ORDER_D1, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'd1, ORDER_D2, 0, 0, 0, 0));
        // single point: position only, derivatives give zero
        plan.push_back(row_of(ROW_CFG, 1, 0, 0, 0, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h5555, ORDER_POS, 1, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h5555, ORDER_D1, 1, 0, 0, 0));
        plan.push_back(row_of(ROW_CFG, 2, 0, 0, 0, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h1234, ORDER_D2, 1, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h1234, ORDER_D1, 1,
                              32'h1_0000, 32'h2_0000, 0));
        // no points in use
        plan.push_back(row_of(ROW_CFG, 0, 0, 0, 0, ORDER_POS, 0, 0, 0, 0));
        plan.push_back(row_of(ROW_EVAL, 0, 0, 0, 18'h8000, ORDER_POS, 1, 0, 0, 0));

        // hold reset, release at a clock edge
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the directed table
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                write_point_count(row.sel);
            end else begin
                send_beat((row.kind == ROW_EVAL) ? OP_EVAL : OP_LOAD, row.sel[INDEX_W-1:0],
                          row.x, row.y, row.prm, row.ord, row.typed, row.want);
            end
        end

        // random phases, each under its own point count
        for (p = 0; p < PHASES; p++) begin
            write_point_count((p < 7) ? phase_pc[p] : 4'($urandom_range(0, 15)));
            if (p == PHASES - 1) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            // long receiver hold-off while the sender keeps offering back to back
            if (p == 1) begin
                tx_gaps = 1'b0;
                hold_request = HOLD_CYCLES;
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == 40) tx_gaps = 1'b1;
                op = ($urandom_range(0, 9) < 3) ? OP_LOAD : OP_EVAL;
                case ($urandom_range(0, 3))
                    0: rp = $urandom;
                    1, 2: rp = $urandom_range(0, 65536);
                    default: rp = param_edges[$urandom_range(0, 7)];
                endcase
                pick = $urandom_range(0, 9);
                ro = (pick < 4) ? ORDER_POS : (pick < 7) ? ORDER_D1 :
                     (pick < 9) ? ORDER_D2 : ORDER_UNUSED;
                send_beat(op, INDEX_W'($urandom_range(0, 7)), rand_coord(), rand_coord(),
                          rp, ro, 1'b0, '0);
            end
        end

        drain_results();
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
